@@ src/pm_pkg.sv @@
// shared widths and command codes of the polynomial multiplier
package pm_pkg;

  localparam int COEF_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int OUT_W  = 36;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULT   = 2'd2;

  // largest and smallest value of a result field
  localparam logic signed [63:0] OUT_MAX = 64'sd34359738367;
  localparam logic signed [63:0] OUT_MIN = -64'sd34359738368;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

@@ src/pm_cell.sv @@
// one tap of the transposed convolution chain: holds one first-polynomial term
module pm_cell #(
  parameter int ACC_W = 36
) (
  input  logic                    clk,
  input  logic                    load_en,
  input  pm_pkg::coef_t           load_coef,
  input  logic                    active,
  input  logic                    clear,
  input  logic                    step,
  input  pm_pkg::coef_t           x,
  input  logic signed [ACC_W-1:0] sum_in,
  output logic signed [ACC_W-1:0] sum_out,
  output logic signed [ACC_W-1:0] sum_nxt
);
  import pm_pkg::*;

  coef_t                   coef_r;
  logic signed [ACC_W-1:0] sum_r;
  prod_t                   prod;

  // inactive taps hold stale terms and must not contribute
  assign prod    = active ? prod_t'(coef_r * x) : '0;
  assign sum_nxt = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod} + sum_in;
  assign sum_out = sum_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      coef_r <= load_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_r <= '0;
    end else if (step) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

@@ src/polynomial_multiply.sv @@
// polynomial multiplier top level: term stores, tap chain and result sequencer
//
// input channel: each item carries a command in in_tuser and a signed Q8.8
// coefficient in in_tdata. command first appends to the first polynomial,
// command second to the second, command multiply appends a last second term
// and starts the product. terms beyond MAX_TERMS are dropped.
// output channel: product coefficients, signed Q20.16, lowest degree first,
// lenA+lenB-1 items (one zero item if the first polynomial is empty), with
// out_tlast on the highest degree. every tap multiplies in parallel, so the
// chain delivers one result per cycle while the receiver accepts; no new
// input item is taken until the last result of the product is registered.
// a stalled receiver freezes the chain and holds the waiting result in the
// output register; nothing is lost. synchronous reset empties both stores
// and drops any product in flight.
module polynomial_multiply #(
  parameter int MAX_TERMS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pm_pkg::COEF_W-1:0]     in_tdata,   // [15:0] coefficient
  input  logic [pm_pkg::CMD_W-1:0]      in_tuser,   // [1:0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pm_pkg::OUT_BYTES_W-1:0] out_tdata, // [35:0] product_coefficient
  output logic                          out_tlast
);
  import pm_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int K_W   = $clog2(2 * MAX_TERMS);
  localparam int SUM_W = PROD_W + $clog2(MAX_TERMS);
  localparam int ACC_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      first_count_r, first_count_nxt;
  logic [CNT_W-1:0]      second_count_r, second_count_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [K_W-1:0]        total;
  coef_t                 second_terms_r [MAX_TERMS];
  coef_t                 x;
  coef_t                 in_coef;
  logic                  in_acc;
  logic                  start;
  logic                  step;
  logic                  step_last;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r;
  logic [OUT_W-1:0]      out_data_r;
  logic [OUT_W-1:0]      sat_val;
  logic signed [ACC_W-1:0] chain [MAX_TERMS+1];
  logic signed [ACC_W-1:0] head_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_coef   = coef_t'(in_tdata);
  assign start     = in_acc && (in_tuser == CMD_MULT);

  // an empty first polynomial still gives one zero result
  assign total = (first_count_r == '0) ? K_W'(1)
               : K_W'(first_count_r) + K_W'(second_count_r) - K_W'(1);

  assign step      = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign step_last = (k_r == total - K_W'(1));

  // second polynomial is fed lowest degree first, then zeros flush the chain
  assign x = (k_r < K_W'(second_count_r)) ? second_terms_r[k_r[IDX_W-1:0]] : '0;

  assign chain[MAX_TERMS] = '0;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic signed [ACC_W-1:0] cell_nxt;

    pm_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk       (clk),
      .load_en   (in_acc && (in_tuser == CMD_FIRST) && (first_count_r == CNT_W'(i))),
      .load_coef (in_coef),
      .active    (CNT_W'(i) < first_count_r),
      .clear     (start),
      .step      (step),
      .x         (x),
      .sum_in    (chain[i+1]),
      .sum_out   (chain[i]),
      .sum_nxt   (cell_nxt)
    );

    if (i == 0) begin : g_head
      assign head_nxt = cell_nxt;
    end
  end

  always_comb begin
    if (head_nxt > SAT_HI) begin
      sat_val = SAT_HI[OUT_W-1:0];
    end else if (head_nxt < SAT_LO) begin
      sat_val = SAT_LO[OUT_W-1:0];
    end else begin
      sat_val = head_nxt[OUT_W-1:0];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    k_nxt            = k_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_FIRST: begin
              if (first_count_r < CNT_W'(MAX_TERMS)) begin
                first_count_nxt = first_count_r + CNT_W'(1);
              end
            end
            CMD_SECOND, CMD_MULT: begin
              if (second_count_r < CNT_W'(MAX_TERMS)) begin
                second_count_nxt = second_count_r + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          if (start) begin
            state_nxt = ST_RUN;
            k_nxt     = '0;
          end
        end
      end
      ST_RUN: begin
        if (step) begin
          out_valid_nxt = 1'b1;
          k_nxt         = k_r + K_W'(1);
          if (step_last) begin
            state_nxt        = ST_IDLE;
            first_count_nxt  = '0;
            second_count_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      k_r            <= '0;
      first_count_r  <= '0;
      second_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      k_r            <= k_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ((in_tuser == CMD_SECOND) || (in_tuser == CMD_MULT))
        && (second_count_r < CNT_W'(MAX_TERMS))) begin
      second_terms_r[second_count_r[IDX_W-1:0]] <= in_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= sat_val;
      out_last_r <= step_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BYTES_W'(out_data_r);
  assign out_tlast  = out_last_r;

  // a last item still waiting during a run belongs to the previous product
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && (state_r == ST_RUN)) |-> (k_r == '0))
    else $error("last result waiting while product already under way");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (k_r < total))
    else $error("result index beyond product length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (first_count_r <= CNT_W'(MAX_TERMS)) && (second_count_r <= CNT_W'(MAX_TERMS)))
    else $error("term count beyond store depth");

  a_run_has_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (second_count_r != '0))
    else $error("product running with empty second polynomial");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (state_r == ST_IDLE)))
    else $error("reset left a result or product pending");

endmodule

@@ tb/polynomial_multiply_tb.sv @@
// testbench for the polynomial multiplier: directed and random products checked item by item
`timescale 1ns / 1ps

module polynomial_multiply_tb;
  import pm_pkg::*;

  localparam int MAX_TERMS   = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 50;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } product_t;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SPARSE} ready_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [COEF_W-1:0]      in_tdata = '0;    // [15:0] coefficient
  logic [CMD_W-1:0]       in_tuser = '0;    // [1:0] command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_BYTES_W-1:0] out_tdata;        // [35:0] product_coefficient
  logic                   out_tlast;

  // predictor state
  coef_t    first_poly [MAX_TERMS];
  coef_t    second_poly[MAX_TERMS];
  int       first_len = 0;
  int       second_len = 0;
  product_t pending_products[$];

  int items_accepted = 0;
  int multiplies_run = 0;
  int products_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_off_request = 0;

  polynomial_multiply #(.MAX_TERMS(MAX_TERMS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // store each taken term and convolve the stored terms once a multiply item is taken
  task automatic convolve_item(input logic [CMD_W-1:0] cmd, input coef_t coef);
    logic signed [63:0] acc;
    int total;
    product_t entry;
    case (cmd)
      CMD_FIRST: begin
        if (first_len < MAX_TERMS) begin
          first_poly[first_len] = coef;
          first_len++;
        end
      end
      CMD_SECOND, CMD_MULT: begin
        if (second_len < MAX_TERMS) begin
          second_poly[second_len] = coef;
          second_len++;
        end
        if (cmd == CMD_MULT) begin
          multiplies_run++;
          if (first_len == 0 || second_len == 0) begin
            entry.value = '0;
            entry.last  = 1'b1;
            pending_products = {pending_products, entry};
          end else begin
            total = first_len + second_len - 1;
            for (int k = 0; k < total; k++) begin
              acc = 0;
              for (int i = 0; i < first_len; i++) begin
                if (k >= i && k - i < second_len)
                  acc = acc + first_poly[i] * second_poly[k - i];
              end
              if (acc > OUT_MAX) acc = OUT_MAX;
              if (acc < OUT_MIN) acc = OUT_MIN;
              entry.value = acc[OUT_W-1:0];
              entry.last  = (k == total - 1);
              pending_products = {pending_products, entry};
            end
          end
          first_len = 0;
          second_len = 0;
        end
      end
      default: ;
    endcase
  endtask

  // offer one item, wait for it to be taken, then pace the sender in bursts
  task automatic send_item(input logic [CMD_W-1:0] cmd, input coef_t coef);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= coef;
    do @(posedge clk); while (!in_tready);
    items_accepted++;
    convolve_item(cmd, coef);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  function automatic coef_t random_coef();
    coef_t extremes[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    if ($urandom_range(0, 5) == 0) return extremes[$urandom_range(0, 4)];
    return coef_t'($urandom());
  endfunction

  // mostly short polynomials, sometimes empty, sometimes past the store size
  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(14, MAX_TERMS + 2);
    return $urandom_range(1, 6);
  endfunction

  // receiver: changes its stall pattern at the end of each randomly long phase, long hold-off on request
  initial begin : receiver
    int hold_left;
    int phase_left;
    ready_mode_t mode;
    hold_left = 0;
    phase_left = 0;
    mode = READY_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (mode)
          READY_ALWAYS:   out_tready <= 1'b1;
          READY_RANDOM:   out_tready <= 1'($urandom_range(0, 1));
          READY_PERIODIC: out_tready <= (phase_left % 4 != 0);
          default:        out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_product
    product_t want;
    if (rst_n && out_tvalid && out_tready) begin
      products_checked++;
      if (pending_products.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected item: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        want = pending_products.pop_front();
        if (out_tdata !== OUT_BYTES_W'(want.value) || out_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                     OUT_BYTES_W'(want.value), want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // multiply with nothing in the first polynomial gives one zero
  task automatic test_empty_first();
    send_item(CMD_MULT, 16'sh1234);
    wait_drained();
  endtask

  task automatic test_extreme_values();
    send_item(CMD_FIRST, 16'sh8000);
    send_item(CMD_FIRST, 16'sh7fff);
    send_item(CMD_SECOND, 16'sh8000);
    send_item(CMD_MULT, 16'sh7fff);
    wait_drained();
  endtask

  // command 3 must leave the stores alone
  task automatic test_unused_command();
    send_item(CMD_FIRST, 16'sh0500);
    send_item(CMD_UNUSED, 16'sh7f7f);
    send_item(CMD_MULT, 16'shff00);
    wait_drained();
  endtask

  // one term past the first store is dropped
  task automatic test_first_store_full();
    repeat (MAX_TERMS + 1) send_item(CMD_FIRST, 16'sh8000);
    send_item(CMD_MULT, 16'sh8000);
    wait_drained();
  endtask

  // receiver holds off while a full-size product and a short one pile up behind it
  task automatic test_backpressure();
    hold_off_request = 400;
    burst_left = 200;
    repeat (MAX_TERMS) send_item(CMD_FIRST, random_coef());
    repeat (MAX_TERMS - 1) send_item(CMD_SECOND, random_coef());
    send_item(CMD_MULT, random_coef());
    send_item(CMD_FIRST, random_coef());
    send_item(CMD_MULT, random_coef());
    burst_left = 0;
    wait_drained();
  endtask

  task automatic test_random_products();
    int sent;
    int len_a;
    int len_b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len_a = random_length();
      len_b = random_length();
      for (int i = 0; i < len_a + len_b + 1; i++) begin
        if ($urandom_range(0, 11) == 0) send_item(CMD_UNUSED, random_coef());
        if (i < len_a) send_item(CMD_FIRST, random_coef());
        else if (i < len_a + len_b) send_item(CMD_SECOND, random_coef());
        else send_item(CMD_MULT, random_coef());
        sent++;
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int drain;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_first();
    test_extreme_values();
    test_unused_command();
    test_first_store_full();
    test_backpressure();
    test_random_products();
    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_products.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * MAX_TERMS + 8) @(posedge clk);
    if (pending_products.size() != 0) begin
      $display("%0d expected items never arrived", pending_products.size());
      error_count += pending_products.size();
    end
    $display("%0d input items taken, %0d multiplies, %0d product items checked, %0d errors",
             items_accepted, multiplies_run, products_checked, error_count);
    $display("covered empty, full-store, extreme-value, unused-command and stalled-output cases");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ polynomial_multiply.f @@
src/pm_pkg.sv
src/pm_cell.sv
src/polynomial_multiply.sv
tb/polynomial_multiply_tb.sv
